FILE: hdl/glv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glv_pkg
// types, codes and helper functions shared by the gear lever interface
// ----------------------------------------------------------------------------
package glv_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CRC_BYTES = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_XOR       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEPALIVE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PARK_HOLD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKLIGHT     = 3'd4;

    localparam logic [7:0] CRC_POLY_RST    = 8'h1D;
    localparam logic [7:0] CRC_XOR_RST     = 8'h70;
    localparam logic [7:0] KEEPALIVE_RST   = 8'd20;
    localparam logic [2:0] PARK_HOLD_RST   = 3'd2;
    localparam logic [7:0] BACKLIGHT_RST   = 8'hFF;

    localparam logic [10:0] CAN_ID_LEVER   = 11'h197;

    localparam logic [7:0] LC_UP1          = 8'h1E;
    localparam logic [7:0] LC_UP2          = 8'h2E;
    localparam logic [7:0] LC_DOWN1        = 8'h3E;
    localparam logic [7:0] LC_DOWN2        = 8'h4E;
    localparam logic [7:0] LC_CENTER       = 8'h0E;
    localparam logic [7:0] LC_SPORT        = 8'h7E;
    localparam logic [7:0] LC_SIDE_DOWN    = 8'h6E;
    localparam logic [7:0] LC_SIDE_UP      = 8'h5E;

    localparam logic [7:0] PARK_PRESSED    = 8'hD5;
    localparam logic [7:0] PARK_RELEASED   = 8'hC0;

    localparam logic [7:0] DIR_CODE_PARK    = 8'h20;
    localparam logic [7:0] DIR_CODE_REVERSE = 8'h40;
    localparam logic [7:0] DIR_CODE_NEUTRAL = 8'h60;
    localparam logic [7:0] DIR_CODE_DRIVE   = 8'h80;

    localparam logic signed [2:0] VDIR_REVERSE = -3'sd1;
    localparam logic signed [2:0] VDIR_NEUTRAL = 3'sd0;
    localparam logic signed [2:0] VDIR_FORWARD = 3'sd1;
    localparam logic signed [2:0] VDIR_PARK    = 3'sd2;

    localparam logic [3:0] ROLL_LAST       = 4'd14;

    localparam logic [1:0] GEAR_PARK       = 2'd0;
    localparam logic [1:0] GEAR_REVERSE    = 2'd1;
    localparam logic [1:0] GEAR_NEUTRAL    = 2'd2;
    localparam logic [1:0] GEAR_DRIVE      = 2'd3;

    localparam logic [1:0] FRAME_STATUS    = 2'd0;
    localparam logic [1:0] FRAME_BACKLIGHT = 2'd1;
    localparam logic [1:0] FRAME_NONE      = 2'd2;

    localparam logic [2:0] LEN_STATUS      = 3'd5;
    localparam logic [2:0] LEN_BACKLIGHT   = 3'd2;
    localparam logic [2:0] LEN_NONE        = 3'd0;

    typedef struct packed {
        logic [7:0] crc_poly;
        logic [7:0] crc_xor;
        logic [7:0] keepalive;
        logic [2:0] park_hold;
        logic [7:0] backlight;
    } glv_cfg_t;

    typedef struct packed {
        logic              func;
        logic              off_mode;
        logic              run_mode;
        logic signed [2:0] vcu_direction;
        logic              ignition_on;
        logic [7:0]        park_code;
        logic [7:0]        lever_code;
        logic [10:0]       can_id;
    } glv_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] b4;
        logic [2:0] len;
        logic [1:0] gear;
        logic       last;
    } glv_result_t;

    typedef struct packed {
        logic        two;
        glv_result_t first;
        glv_result_t second;
    } glv_pair_t;

    // one byte of msb-first crc-8
    function automatic logic [7:0] glv_crc_step(input logic [7:0] c_in,
                                                input logic [7:0] poly);
        logic [7:0] c;
        c = c_in;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // status frame bytes one to four, in crc order
    function automatic logic [7:0] glv_crc_data(input glv_result_t r,
                                                input logic [1:0] idx);
        logic [7:0] d;
        case (idx)
            2'd0:    d = r.b1;
            2'd1:    d = r.b2;
            2'd2:    d = r.b3;
            default: d = r.b4;
        endcase
        return d;
    endfunction

endpackage

FILE: hdl/glv_lever_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glv_lever_core
// lever frame decode, keep-alive countdown, lever state machine and
// status / backlight frame assembly for one accepted word
// ----------------------------------------------------------------------------
module glv_lever_core
    import glv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      take,
    input  glv_item_t item,
    input  glv_cfg_t  cfg,
    output logic      pair_valid,
    output glv_pair_t pair
);

    typedef enum logic [2:0] {
        POS_OFF     = 3'd0,
        POS_NEUTRAL = 3'd1,
        POS_REVERSE = 3'd2,
        POS_DRIVE   = 3'd3,
        POS_SPORT   = 3'd4,
        POS_PARK    = 3'd5
    } pos_t;

    typedef struct packed {
        logic up1;
        logic up2;
        logic down2;
        logic park;
        logic side_down;
        logic side_up;
    } press_t;

    pos_t              pos_reg, pos_next;
    logic [1:0]        gear_reg, gear_next;
    press_t            press_reg, press_next;
    logic              sport_req_reg, sport_req_next;
    logic              dir_latch_reg, dir_latch_next;
    logic              park_latch_reg, park_latch_next;
    logic              sport_latch_reg, sport_latch_next;
    logic [2:0]        park_cnt_reg, park_cnt_next;
    logic [7:0]        ka_cnt_reg, ka_cnt_next;
    logic [3:0]        roll_reg, roll_next;
    logic [7:0]        step_reg, step_next;
    logic signed [2:0] sdir_reg, sdir_next;
    logic              srun_reg, srun_next;
    logic [7:0]        dirout_reg, dirout_next;

    logic              park_edge;
    logic [2:0]        park_cnt_inc;

    assign park_edge    = press_reg.park && !park_latch_reg;
    assign park_cnt_inc = (park_cnt_reg < 3'd7) ? park_cnt_reg + 3'd1 : park_cnt_reg;

    always_comb
    begin
        pos_next         = pos_reg;
        gear_next        = gear_reg;
        press_next       = press_reg;
        sport_req_next   = sport_req_reg;
        dir_latch_next   = dir_latch_reg;
        park_latch_next  = park_latch_reg;
        sport_latch_next = sport_latch_reg;
        park_cnt_next    = park_cnt_reg;
        ka_cnt_next      = ka_cnt_reg;
        roll_next        = roll_reg;
        step_next        = step_reg;
        sdir_next        = sdir_reg;
        srun_next        = srun_reg;
        dirout_next      = dirout_reg;
        pair             = '0;
        pair_valid       = take && item.func;

        if (take && !item.func)
        begin
            if (item.can_id == CAN_ID_LEVER)
            begin
                press_next = '0;
                case (item.lever_code)
                    LC_UP1:       press_next.up1 = 1'b1;
                    LC_UP2:       press_next.up2 = 1'b1;
                    LC_DOWN2:     press_next.down2 = 1'b1;
                    LC_CENTER:
                    begin
                        dir_latch_next = 1'b0;
                        sport_req_next = 1'b0;
                    end
                    LC_SPORT:
                    begin
                        sport_req_next   = 1'b1;
                        sport_latch_next = 1'b0;
                    end
                    LC_SIDE_DOWN: press_next.side_down = 1'b1;
                    LC_SIDE_UP:   press_next.side_up = 1'b1;
                    default:      ;
                endcase
                if (item.park_code == PARK_PRESSED)
                begin
                    park_cnt_next   = park_cnt_inc;
                    press_next.park = park_cnt_inc > cfg.park_hold;
                end
                else if (item.park_code == PARK_RELEASED)
                begin
                    park_cnt_next   = '0;
                    park_latch_next = 1'b0;
                end
            end
        end
        else if (take)
        begin
            if (!item.ignition_on)
                ka_cnt_next = (ka_cnt_reg != 8'd0) ? ka_cnt_reg - 8'd1 : ka_cnt_reg;
            else
                ka_cnt_next = cfg.keepalive;

            if (ka_cnt_next != 8'd0)
            begin
                unique case (pos_reg)
                    POS_OFF: pos_next = POS_NEUTRAL;
                    POS_NEUTRAL:
                    begin
                        if (!dir_latch_reg)
                        begin
                            if (press_reg.up2)
                            begin
                                pos_next = POS_REVERSE;
                                gear_next = GEAR_REVERSE;
                                dir_latch_next = 1'b1;
                            end
                            else if (press_reg.down2)
                            begin
                                pos_next = POS_DRIVE;
                                gear_next = GEAR_DRIVE;
                                dir_latch_next = 1'b1;
                            end
                            else if (park_edge)
                            begin
                                pos_next = POS_PARK;
                                gear_next = GEAR_PARK;
                                park_latch_next = 1'b1;
                            end
                        end
                    end
                    POS_REVERSE:
                    begin
                        if (press_reg.down2 && !dir_latch_reg)
                        begin
                            pos_next = POS_NEUTRAL;
                            gear_next = GEAR_NEUTRAL;
                            dir_latch_next = 1'b1;
                        end
                        else if (park_edge)
                        begin
                            pos_next = POS_PARK;
                            gear_next = GEAR_PARK;
                            park_latch_next = 1'b1;
                        end
                    end
                    POS_DRIVE:
                    begin
                        if (press_reg.up1 && !dir_latch_reg)
                        begin
                            pos_next = POS_NEUTRAL;
                            gear_next = GEAR_NEUTRAL;
                            dir_latch_next = 1'b1;
                        end
                        else if (sport_req_reg)
                            pos_next = POS_SPORT;
                        else if (park_edge)
                        begin
                            pos_next = POS_PARK;
                            gear_next = GEAR_PARK;
                            park_latch_next = 1'b1;
                        end
                    end
                    POS_SPORT:
                    begin
                        if (!sport_req_reg)
                        begin
                            pos_next = POS_DRIVE;
                            gear_next = GEAR_DRIVE;
                        end
                        else if (park_edge)
                        begin
                            pos_next = POS_PARK;
                            gear_next = GEAR_PARK;
                            park_latch_next = 1'b1;
                        end
                        if (press_reg.side_down && !sport_latch_reg)
                        begin
                            if (step_reg != 8'hFF)
                                step_next = step_reg + 8'd1;
                            sport_latch_next = 1'b1;
                        end
                        else if (press_reg.side_up && !sport_latch_reg && step_reg != 8'd0)
                        begin
                            step_next = step_reg - 8'd1;
                            sport_latch_next = 1'b1;
                        end
                    end
                    POS_PARK:
                    begin
                        if (park_edge)
                        begin
                            pos_next = POS_NEUTRAL;
                            gear_next = GEAR_NEUTRAL;
                            park_latch_next = 1'b1;
                        end
                    end
                    default: ;
                endcase

                // unknown saved direction keeps the previous code
                if (!srun_reg)
                    dirout_next = DIR_CODE_PARK;
                else if (sdir_reg == VDIR_NEUTRAL)
                    dirout_next = DIR_CODE_NEUTRAL;
                else if (sdir_reg == VDIR_REVERSE)
                    dirout_next = DIR_CODE_REVERSE;
                else if (sdir_reg == VDIR_FORWARD)
                    dirout_next = DIR_CODE_DRIVE;
                else if (sdir_reg == VDIR_PARK)
                    dirout_next = DIR_CODE_PARK;

                pair.two          = 1'b1;
                pair.first.kind   = FRAME_STATUS;
                pair.first.b1     = {4'd0, roll_reg};
                pair.first.b2     = dirout_next;
                pair.first.b4     = step_next;
                pair.first.len    = LEN_STATUS;
                pair.second.kind  = FRAME_BACKLIGHT;
                pair.second.b0    = srun_reg ? cfg.backlight : 8'd0;
                pair.second.len   = LEN_BACKLIGHT;
                pair.second.last  = 1'b1;
                roll_next = (roll_reg >= ROLL_LAST) ? 4'd0 : roll_reg + 4'd1;
            end
            else
            begin
                pair.first.kind = FRAME_NONE;
                pair.first.len  = LEN_NONE;
                pair.first.last = 1'b1;
            end

            sdir_next = item.vcu_direction;
            srun_next = item.run_mode;
            if (item.off_mode)
                gear_next = GEAR_NEUTRAL;
            pair.first.gear  = gear_next;
            pair.second.gear = gear_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= POS_OFF;
            gear_reg        <= GEAR_NEUTRAL;
            press_reg       <= '0;
            sport_req_reg   <= 1'b0;
            dir_latch_reg   <= 1'b0;
            park_latch_reg  <= 1'b0;
            sport_latch_reg <= 1'b0;
            park_cnt_reg    <= '0;
            ka_cnt_reg      <= KEEPALIVE_RST;
            roll_reg        <= '0;
            step_reg        <= '0;
            sdir_reg        <= VDIR_NEUTRAL;
            srun_reg        <= 1'b0;
            dirout_reg      <= '0;
        end
        else
        begin
            pos_reg         <= pos_next;
            gear_reg        <= gear_next;
            press_reg       <= press_next;
            sport_req_reg   <= sport_req_next;
            dir_latch_reg   <= dir_latch_next;
            park_latch_reg  <= park_latch_next;
            sport_latch_reg <= sport_latch_next;
            park_cnt_reg    <= park_cnt_next;
            ka_cnt_reg      <= ka_cnt_next;
            roll_reg        <= roll_next;
            step_reg        <= step_next;
            sdir_reg        <= sdir_next;
            srun_reg        <= srun_next;
            dirout_reg      <= dirout_next;
        end
    end

endmodule

FILE: hdl/glv_crc_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glv_crc_pipe
// crc-8 over status bytes one to four, one byte per stage, final xor at exit
// ----------------------------------------------------------------------------
module glv_crc_pipe
    import glv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] crc_poly,
    input  logic [7:0] crc_xor,
    input  logic       in_valid,
    output logic       in_ready,
    input  glv_pair_t  in_pair,
    output logic       out_valid,
    input  logic       out_ready,
    output glv_pair_t  out_pair
);

    localparam int N  = CRC_BYTES;
    localparam int IW = $clog2(N);

    logic [N-1:0] vld_reg;
    glv_pair_t    pair_reg [N];
    logic [7:0]   crc_reg  [N];
    logic         advance;

    assign advance  = !vld_reg[N-1] || out_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= {vld_reg[N-2:0], in_valid};
    end

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        glv_pair_t  stage_pair;
        logic [7:0] stage_crc;

        if (i == 0)
        begin : g_first
            assign stage_pair = in_pair;
            assign stage_crc  = 8'd0;
        end
        else
        begin : g_rest
            assign stage_pair = pair_reg[i-1];
            assign stage_crc  = crc_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                pair_reg[i] <= stage_pair;
                crc_reg[i]  <= glv_crc_step(stage_crc ^
                                   glv_crc_data(stage_pair.first, IW'(i)), crc_poly);
            end
        end
    end

    always_comb
    begin
        out_pair = pair_reg[N-1];
        if (pair_reg[N-1].first.kind == FRAME_STATUS)
            out_pair.first.b0 = crc_reg[N-1] ^ crc_xor;
    end

    assign out_valid = vld_reg[N-1];

endmodule

FILE: hdl/glv_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glv_out_stage
// two-slot result register, sends a status / backlight pair as two words
// ----------------------------------------------------------------------------
module glv_out_stage
    import glv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  glv_pair_t   in_pair,
    output logic        word_valid,
    input  logic        word_ready,
    output glv_result_t word
);

    logic        slot0_v_reg, slot1_v_reg;
    glv_result_t slot0_reg, slot1_reg;
    logic        pop, load;

    assign pop        = slot0_v_reg && word_ready;
    assign in_ready   = !slot0_v_reg || (pop && !slot1_v_reg);
    assign load       = in_valid && in_ready;
    assign word_valid = slot0_v_reg;
    assign word       = slot0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot0_v_reg <= 1'b0;
            slot1_v_reg <= 1'b0;
        end
        else if (load)
        begin
            slot0_v_reg <= 1'b1;
            slot1_v_reg <= in_pair.two;
        end
        else if (pop)
        begin
            slot0_v_reg <= slot1_v_reg;
            slot1_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot0_reg <= in_pair.first;
            slot1_reg <= in_pair.second;
        end
        else if (pop)
            slot0_reg <= slot1_reg;
    end

endmodule

FILE: hdl/gear_lever_interface_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gear_lever_interface_core
// gear lever frame decoder and status / backlight frame generator
// ----------------------------------------------------------------------------
// s_axis carries one word per lever frame (tuser 0) or 100 ms tick (tuser 1).
// m_axis returns the frames a tick causes: a status word then a backlight
// word (tlast on the second), or one empty report word when the lever is not
// serviced. lever frames give no output word.
// cfg_* writes the five configuration registers by index, one per cycle,
// always ready; write only while the block is idle.
// path: a tick's first word passes the input word register, the four
// byte-per-stage crc pipeline stages and a result slot before it is valid.
// throughput: lever frames one per cycle while no tick waits in the input
// register; ticks are bounded by the two words each sends through one output port.
// reset: registers return to their defaults, lever off, gear neutral,
// keep-alive 20 ticks, all latches clear, no words in flight.
// a stall on m_axis holds the result slots and the crc stages, then drops
// s_axis_tready once a tick waits for them; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module gear_lever_interface_core
    import glv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [39:0]          s_axis_tdata,   // can_id, lever_code, park_code,
                                                 // ignition_on, vcu_direction,
                                                 // run_mode, off_mode
    input  logic [0:0]           s_axis_tuser,   // func
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [47:0]          m_axis_tdata,   // byte_zero .. byte_four,
                                                 // frame_length, gear
    output logic [1:0]           m_axis_tuser,   // frame_kind
    output logic                 m_axis_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    glv_cfg_t    cfg_reg;
    glv_item_t   item_reg;
    logic        in_valid_reg;
    logic        take;
    logic        core_pair_valid;
    glv_pair_t   core_pair;
    logic        pipe_in_ready;
    logic        pipe_out_valid;
    glv_pair_t   pipe_out_pair;
    logic        out_in_ready;
    glv_result_t out_word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crc_poly  <= CRC_POLY_RST;
            cfg_reg.crc_xor   <= CRC_XOR_RST;
            cfg_reg.keepalive <= KEEPALIVE_RST;
            cfg_reg.park_hold <= PARK_HOLD_RST;
            cfg_reg.backlight <= BACKLIGHT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CRC_POLY:  cfg_reg.crc_poly  <= cfg_data;
                CFG_CRC_XOR:   cfg_reg.crc_xor   <= cfg_data;
                CFG_KEEPALIVE: cfg_reg.keepalive <= cfg_data;
                CFG_PARK_HOLD: cfg_reg.park_hold <= cfg_data[2:0];
                CFG_BACKLIGHT: cfg_reg.backlight <= cfg_data;
                default:       ;
            endcase
        end
    end

    // input word register
    assign take          = in_valid_reg && (!item_reg.func || pipe_in_ready);
    assign s_axis_tready = !in_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            item_reg <= {s_axis_tuser, s_axis_tdata[32:0]};
    end

    glv_lever_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .item       (item_reg),
        .cfg        (cfg_reg),
        .pair_valid (core_pair_valid),
        .pair       (core_pair)
    );

    glv_crc_pipe u_crc (
        .clk       (clk),
        .rst_n     (rst_n),
        .crc_poly  (cfg_reg.crc_poly),
        .crc_xor   (cfg_reg.crc_xor),
        .in_valid  (core_pair_valid),
        .in_ready  (pipe_in_ready),
        .in_pair   (core_pair),
        .out_valid (pipe_out_valid),
        .out_ready (out_in_ready),
        .out_pair  (pipe_out_pair)
    );

    glv_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (pipe_out_valid),
        .in_ready   (out_in_ready),
        .in_pair    (pipe_out_pair),
        .word_valid (m_axis_tvalid),
        .word_ready (m_axis_tready),
        .word       (out_word)
    );

    assign m_axis_tdata = {3'b000, out_word.gear, out_word.len, out_word.b4,
                           out_word.b3, out_word.b2, out_word.b1, out_word.b0};
    assign m_axis_tuser = out_word.kind;
    assign m_axis_tlast = out_word.last;

    // only a status word is ever followed by another word of the same tick
    a_status_first: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == FRAME_STATUS)
        else $error("non-final word is not a status frame");

    a_backlight_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && m_axis_tlast && m_axis_tuser == FRAME_BACKLIGHT)
        else $error("backlight word does not follow status word");

    a_none_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == FRAME_NONE |->
            m_axis_tlast && out_word.len == LEN_NONE && out_word.b0 == 8'd0)
        else $error("empty report word carries data");

    a_lever_no_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        take && !item_reg.func |-> !core_pair_valid)
        else $error("lever frame produced a result");

endmodule
